// ===== design/srecord_loader_parser_unit_macros.svh =====
// assertion macros for the s-record loader parser
`ifndef SRECORD_LOADER_PARSER_UNIT_MACROS_SVH
`define SRECORD_LOADER_PARSER_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define SRL_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked out of reset
`define SRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SRL_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define SRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/srec_pkg.sv =====
`timescale 1ns / 1ps
package srec_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_WRITE   = 3'd0,
    KIND_OUTWIN  = 3'd1,
    KIND_ENTRY   = 3'd2,
    KIND_GO      = 3'd3,
    KIND_HELLO   = 3'd4,
    KIND_BADTYPE = 3'd5,
    KIND_SHORT   = 3'd6,
    KIND_BADSUM  = 3'd7
  } kind_t;

  // parser phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_TYPE    = 4'd1,
    PH_CNT_HI  = 4'd2,
    PH_CNT_LO  = 4'd3,
    PH_A3_HI   = 4'd4,
    PH_A3_LO   = 4'd5,
    PH_A2_HI   = 4'd6,
    PH_A2_LO   = 4'd7,
    PH_A1_HI   = 4'd8,
    PH_A1_LO   = 4'd9,
    PH_A0_HI   = 4'd10,
    PH_A0_LO   = 4'd11,
    PH_DATA_HI = 4'd12,
    PH_DATA_LO = 4'd13
  } phase_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_WIN_LOW  = 1'b0,
    CFG_WIN_HIGH = 1'b1
  } cfg_idx_t;

  // one result item
  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [7:0]  data;
  } res_t;

  // characters
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_7    = 8'h37;

  localparam logic [3:0]  HEX_ADJ         = 4'd7;
  localparam logic [7:0]  SUM_OK          = 8'hFF;
  localparam logic [7:0]  MIN_COUNT       = 8'd5;
  localparam logic [31:0] ENTRY_RESET     = 32'h2000_0000;
  localparam logic [31:0] WIN_LOW_RESET   = 32'h2000_0000;
  localparam logic [31:0] WIN_HIGH_RESET  = 32'h2000_0FFF - 32'd64;

endpackage

// ===== design/srec_parse.sv =====
`timescale 1ns / 1ps
module srec_parse
  import srec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        step,
  input  logic [7:0]  rx_char,
  output logic        res_valid,
  output res_t        res,
  output logic        stopped
);

  phase_t      phase_r, phase_nxt;
  logic        is_entry_r, is_entry_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  check_sum_r, check_sum_nxt;
  logic [31:0] cur_addr_r, cur_addr_nxt;
  logic [3:0]  data_high_r, data_high_nxt;
  logic [31:0] entry_addr_r, entry_addr_nxt;
  logic        stopped_r, stopped_nxt;
  logic [31:0] win_low_r, win_high_r;

  logic [3:0]  nib;
  logic [7:0]  cnt_full;
  logic [31:0] cur_shift;
  logic [7:0]  data_byte;
  logic [7:0]  bc_dec;
  logic [7:0]  sum_data;
  logic        in_window;
  logic        active;

  // hex digit decode, never rejects a character
  assign nib       = (rx_char > CH_NINE) ? (rx_char[3:0] - HEX_ADJ) : rx_char[3:0];
  assign cnt_full  = {byte_count_r[3:0], nib};
  assign cur_shift = {cur_addr_r[27:0], nib};
  assign data_byte = {data_high_r, nib};
  assign bc_dec    = byte_count_r - 8'd1;
  assign sum_data  = check_sum_r + data_byte;
  assign in_window = (cur_addr_r >= win_low_r) && (cur_addr_r <= win_high_r);
  assign active    = step && !stopped_r;
  assign stopped   = stopped_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (active) begin
      case (phase_r)
        PH_IDLE: begin
          if (rx_char == CH_S) phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          if (rx_char == CH_ZERO) phase_nxt = PH_IDLE;
          else if (rx_char == CH_3 || rx_char == CH_7) phase_nxt = PH_CNT_HI;
        end
        PH_CNT_HI:  phase_nxt = PH_CNT_LO;
        PH_CNT_LO: begin
          if (cnt_full >= MIN_COUNT) phase_nxt = PH_A3_HI;
        end
        PH_A3_HI:   phase_nxt = PH_A3_LO;
        PH_A3_LO:   phase_nxt = PH_A2_HI;
        PH_A2_HI:   phase_nxt = PH_A2_LO;
        PH_A2_LO:   phase_nxt = PH_A1_HI;
        PH_A1_HI:   phase_nxt = PH_A1_LO;
        PH_A1_LO:   phase_nxt = PH_A0_HI;
        PH_A0_HI:   phase_nxt = PH_A0_LO;
        PH_A0_LO:   phase_nxt = PH_DATA_HI;
        PH_DATA_HI: phase_nxt = PH_DATA_LO;
        PH_DATA_LO: phase_nxt = (bc_dec == 8'd0) ? PH_IDLE : PH_DATA_HI;
        default:    phase_nxt = PH_IDLE;
      endcase
    end
  end

  // datapath updates and result
  always_comb begin
    is_entry_nxt   = is_entry_r;
    byte_count_nxt = byte_count_r;
    check_sum_nxt  = check_sum_r;
    cur_addr_nxt   = cur_addr_r;
    data_high_nxt  = data_high_r;
    entry_addr_nxt = entry_addr_r;
    stopped_nxt    = stopped_r;
    res_valid      = 1'b0;
    res.kind       = KIND_WRITE;
    res.address    = 32'd0;
    res.data       = 8'd0;
    if (active) begin
      case (phase_r)
        PH_IDLE: begin
          if (rx_char == CH_S) begin
            check_sum_nxt = 8'd0;
          end else if (rx_char == CH_G) begin
            stopped_nxt = 1'b1;
            res_valid   = 1'b1;
            res.kind    = KIND_GO;
            res.address = entry_addr_r;
          end else if (rx_char == CH_ESC || rx_char == CH_LF) begin
            res_valid = 1'b1;
            res.kind  = KIND_HELLO;
          end
        end
        PH_TYPE: begin
          if (rx_char == CH_3) begin
            is_entry_nxt = 1'b0;
          end else if (rx_char == CH_7) begin
            is_entry_nxt = 1'b1;
          end else if (rx_char != CH_ZERO) begin
            stopped_nxt = 1'b1;
            res_valid   = 1'b1;
            res.kind    = KIND_BADTYPE;
            res.data    = rx_char;
          end
        end
        PH_CNT_HI: byte_count_nxt = {4'd0, nib};
        PH_CNT_LO: begin
          byte_count_nxt = cnt_full;
          if (cnt_full < MIN_COUNT) begin
            stopped_nxt = 1'b1;
            res_valid   = 1'b1;
            res.kind    = KIND_SHORT;
          end else begin
            check_sum_nxt = check_sum_r + cnt_full;
            cur_addr_nxt  = 32'd0;
          end
        end
        PH_A3_HI, PH_A2_HI, PH_A1_HI, PH_A0_HI: cur_addr_nxt = cur_shift;
        PH_A3_LO, PH_A2_LO, PH_A1_LO, PH_A0_LO: begin
          byte_count_nxt = bc_dec;
          cur_addr_nxt   = cur_shift;
          check_sum_nxt  = check_sum_r + cur_shift[7:0];
        end
        PH_DATA_HI: data_high_nxt = nib;
        PH_DATA_LO: begin
          check_sum_nxt  = sum_data;
          byte_count_nxt = bc_dec;
          if (bc_dec == 8'd0) begin
            // record end: checksum first, then entry
            if (is_entry_r) entry_addr_nxt = cur_addr_r;
            if (sum_data != SUM_OK) begin
              stopped_nxt = 1'b1;
              res_valid   = 1'b1;
              res.kind    = KIND_BADSUM;
            end else if (is_entry_r) begin
              res_valid   = 1'b1;
              res.kind    = KIND_ENTRY;
              res.address = cur_addr_r;
            end
          end else begin
            cur_addr_nxt = cur_addr_r + 32'd1;
            res_valid    = 1'b1;
            res.kind     = in_window ? KIND_WRITE : KIND_OUTWIN;
            res.address  = cur_addr_r;
            res.data     = data_byte;
          end
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      is_entry_r   <= 1'b0;
      byte_count_r <= 8'd0;
      check_sum_r  <= 8'd0;
      cur_addr_r   <= 32'd0;
      data_high_r  <= 4'd0;
      entry_addr_r <= ENTRY_RESET;
      stopped_r    <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      is_entry_r   <= is_entry_nxt;
      byte_count_r <= byte_count_nxt;
      check_sum_r  <= check_sum_nxt;
      cur_addr_r   <= cur_addr_nxt;
      data_high_r  <= data_high_nxt;
      entry_addr_r <= entry_addr_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

  // address window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r  <= WIN_LOW_RESET;
      win_high_r <= WIN_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIN_LOW:  win_low_r  <= cfg_wdata;
        CFG_WIN_HIGH: win_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/srec_out_buf.sv =====
`timescale 1ns / 1ps
module srec_out_buf
  import srec_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam logic [1:0] DEPTH = 2'd2;

  res_t       slot0_r, slot1_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign space     = (cnt_r != DEPTH);
  assign out_res   = slot0_r;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_nxt;
  end

  // head and skid slots
  always_ff @(posedge clk) begin
    if (push && (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))) slot0_r <= push_res;
    else if (pop && cnt_r == DEPTH) slot0_r <= slot1_r;
    if (push && cnt_r == 2'd1 && !pop) slot1_r <= push_res;
  end

endmodule

// ===== design/srecord_loader_parser_unit.sv =====
`timescale 1ns / 1ps
// S-record loader parser. Characters of an S0/S3/S7 record stream enter on the
// in_ channel, one per item; results leave on the out_ channel as kind,
// address and data. A data byte gives a write or an out-of-window item, an S7
// record an entry item, 'g' a go item, ESC or LF a greeting item; a bad type,
// short count or bad checksum gives an error item. Errors and go stop the
// block: it keeps taking characters but gives nothing more until reset.
// The cfg_ port writes the address window (index 0 low, 1 high); the user
// must write it only while idle: the block itself does not enforce this.
// An accepted character waits in the input register; the combinational
// parser step then pushes its result into the two-entry output buffer,
// which shows it on out_. Throughput: one character per cycle while the
// output buffer has space. When the receiver stalls, the output buffer
// fills; in_ready drops once both entries are taken and the input register
// holds a character; nothing is lost. Reset (synchronous, active low)
// returns to waiting for 'S', entry address 0x20000000 and the default window.
`include "srecord_loader_parser_unit_macros.svh"
module srecord_loader_parser_unit
  import srec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_address,
  output logic [7:0]  out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic       in_v_r;
  logic [7:0] in_char_r;
  logic       advance;
  logic       ob_space;
  logic       res_valid;
  res_t       res;
  res_t       out_res;
  logic       stopped;

  assign advance  = in_v_r && ob_space;
  assign in_ready = !in_v_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) in_v_r <= 1'b0;
    else if (in_ready) in_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_char_r <= in_rx_char;
  end

  // parser step
  srec_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_idx_t'(cfg_index)),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .rx_char   (in_char_r),
    .res_valid (res_valid),
    .res       (res),
    .stopped   (stopped)
  );

  // result buffer
  srec_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance && res_valid),
    .push_res  (res),
    .space     (ob_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind    = out_res.kind;
  assign out_address = out_res.address;
  assign out_data    = out_res.data;

  // checks
  `SRL_ASSERT_NEXT(a_stop_holds, clk, rst_n, stopped, stopped, "parser left stopped state")
  `SRL_ASSERT_NEXT(a_res_shown, clk, rst_n, advance && res_valid, out_valid, "result not shown")
  `SRL_ASSERT(a_stop_cause, clk, rst_n, $rose(stopped), $past(advance && res_valid && (res.kind == KIND_GO || res.kind == KIND_BADTYPE || res.kind == KIND_SHORT || res.kind == KIND_BADSUM)), "stopped without go or error item")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import srec_pkg::*;

  localparam int unsigned ITEM_GOAL   = 1800;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned SETTLE_PAD  = 8;
  localparam logic [7:0]  CH_A_UP     = 8'h41;
  localparam logic [7:0]  CH_CR       = 8'h0D;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_char = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_address;
  logic [7:0]  out_data;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_WIN_LOW;
  logic [31:0] cfg_wdata = 32'h0;

  srecord_loader_parser_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_char(in_rx_char),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_address(out_address),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // characters waiting to be sent and results still owed by the block
  logic [7:0]  char_q[$];
  res_t        due_results[$];
  int unsigned err_count = 0;
  int unsigned live_chars = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_token = 0;

  // parser shadow state
  phase_t      ph;
  bit          rec_entry;
  bit          halted;
  logic [7:0]  cnt;
  logic [7:0]  csum;
  logic [7:0]  dhi;
  logic [31:0] cur_addr;
  logic [31:0] entry_addr;
  logic [31:0] win_lo = WIN_LOW_RESET;
  logic [31:0] win_hi = WIN_HIGH_RESET;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // hex digit value: anything above '9' drops by 7, low nibble kept
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] t;
    t = (c > CH_NINE) ? c - {4'd0, HEX_ADJ} : c;
    return t[3:0];
  endfunction

  // advance the shadow parser by one accepted character
  function automatic void parse_char(input logic [7:0] c);
    logic [3:0]  n;
    logic [7:0]  d;
    logic [31:0] a;
    res_t        r;
    bit          have;
    n = nibble_of(c);
    r = '0;
    have = 1'b0;
    if (!halted) begin
      case (ph)
        PH_IDLE: begin
          if (c == CH_S) begin
            csum = 8'h00;
            ph = PH_TYPE;
          end else if (c == CH_G) begin
            halted = 1'b1;
            r.kind = KIND_GO;
            r.address = entry_addr;
            have = 1'b1;
          end else if (c == CH_ESC || c == CH_LF) begin
            r.kind = KIND_HELLO;
            have = 1'b1;
          end
        end
        PH_TYPE: begin
          if (c == CH_ZERO) begin
            ph = PH_IDLE;
          end else if (c == CH_3) begin
            rec_entry = 1'b0;
            ph = PH_CNT_HI;
          end else if (c == CH_7) begin
            rec_entry = 1'b1;
            ph = PH_CNT_HI;
          end else begin
            halted = 1'b1;
            r.kind = KIND_BADTYPE;
            r.data = c;
            have = 1'b1;
          end
        end
        PH_CNT_HI: begin
          cnt = {4'd0, n};
          ph = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          cnt = {cnt[3:0], n};
          if (cnt < MIN_COUNT) begin
            halted = 1'b1;
            r.kind = KIND_SHORT;
            have = 1'b1;
          end else begin
            csum = csum + cnt;
            cur_addr = 32'h0;
            ph = PH_A3_HI;
          end
        end
        PH_A3_HI, PH_A2_HI, PH_A1_HI, PH_A0_HI: begin
          cur_addr = {cur_addr[27:0], n};
          ph = phase_t'(ph + 4'd1);
        end
        PH_A3_LO, PH_A2_LO, PH_A1_LO, PH_A0_LO: begin
          cnt = cnt - 8'd1;
          cur_addr = {cur_addr[27:0], n};
          csum = csum + cur_addr[7:0];
          ph = phase_t'(ph + 4'd1);
        end
        PH_DATA_HI: begin
          dhi = {4'd0, n};
          ph = PH_DATA_LO;
        end
        PH_DATA_LO: begin
          d = {dhi[3:0], n};
          csum = csum + d;
          cnt = cnt - 8'd1;
          if (cnt == 8'd0) begin
            // record end: checksum wins over the entry report
            ph = PH_IDLE;
            if (rec_entry) entry_addr = cur_addr;
            if (csum != SUM_OK) begin
              halted = 1'b1;
              r.kind = KIND_BADSUM;
              have = 1'b1;
            end else if (rec_entry) begin
              r.kind = KIND_ENTRY;
              r.address = entry_addr;
              have = 1'b1;
            end
          end else begin
            a = cur_addr;
            r.kind = (a >= win_lo && a <= win_hi) ? KIND_WRITE : KIND_OUTWIN;
            r.address = a;
            r.data = d;
            have = 1'b1;
            cur_addr = a + 32'd1;
            ph = PH_DATA_HI;
          end
        end
        default: ph = PH_IDLE;
      endcase
    end
    if (have) due_results.push_back(r);
  endfunction

  // sender: offers queued characters, predicts on each accepted item
  logic [4:0] send_gap = 5'd0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 5'd0;
      ph = PH_IDLE;
      rec_entry = 1'b0;
      halted = 1'b0;
      cnt = 8'h00;
      csum = 8'h00;
      dhi = 8'h00;
      cur_addr = 32'h0;
      entry_addr = ENTRY_RESET;
    end else begin
      if (in_valid && in_ready) parse_char(in_rx_char);
      if (!in_valid || in_ready) begin
        if (send_gap != 5'd0) begin
          send_gap <= send_gap - 5'd1;
          in_valid <= 1'b0;
        end else if (char_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
          send_gap <= 5'($urandom_range(0, 15));
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_rx_char <= char_q.pop_front();
        end
      end
    end
  end

  // receiver ready: random stall bursts plus a long hold-off on request
  logic [4:0]  recv_gap = 5'd0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap <= 5'd0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (recv_gap != 5'd0) begin
      recv_gap <= recv_gap - 5'd1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      recv_gap <= 5'($urandom_range(0, 15));
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  res_t head;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        flag_mismatch("unexpected result, kind", 32'(out_kind), 32'h0);
      end else begin
        head = due_results.pop_front();
        if (out_kind !== head.kind)
          flag_mismatch("kind", 32'(out_kind), 32'(head.kind));
        if (out_address !== head.address)
          flag_mismatch("address", out_address, head.address);
        if (out_data !== head.data)
          flag_mismatch("data", 32'(out_data), 32'(head.data));
      end
    end
  end

  // ascii for one hex digit; odd may pick any character that decodes to it
  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit odd);
    logic [7:0] c;
    if (odd && $urandom_range(0, 2) == 0) begin
      c = 8'($urandom_range(0, 255));
      while (nibble_of(c) != n) c = 8'($urandom_range(0, 255));
    end else begin
      c = (n < 4'd10) ? CH_ZERO + 8'(n) : CH_A_UP + 8'(n) - 8'd10;
    end
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit odd);
    char_q.push_back(hex_char(b[7:4], odd));
    char_q.push_back(hex_char(b[3:0], odd));
  endtask

  task automatic push_eol();
    case ($urandom_range(0, 3))
      0: begin
        char_q.push_back(CH_CR);
        char_q.push_back(CH_LF);
      end
      1: char_q.push_back(CH_LF);
      2: char_q.push_back(CH_CR);
      default: ;
    endcase
  endtask

  // one S3 or S7 record with random data bytes
  task automatic push_record(input logic [7:0] rtype, input logic [31:0] addr,
                             input int unsigned nbytes, input bit odd,
                             input bit bad_sum);
    logic [7:0]  count;
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned i;
    count = 8'(nbytes + 5);
    char_q.push_back(CH_S);
    char_q.push_back(rtype);
    push_byte(count, odd);
    sum = count;
    for (i = 0; i < 4; i++) begin
      b = addr[31 - 8 * i -: 8];
      push_byte(b, odd);
      sum = sum + b;
    end
    for (i = 0; i < nbytes; i++) begin
      b = 8'($urandom);
      push_byte(b, odd);
      sum = sum + b;
    end
    b = SUM_OK - sum;
    if (bad_sum) b = b ^ 8'($urandom_range(1, 255));
    push_byte(b, odd);
    live_chars += 2 + 2 * (nbytes + 6);
    push_eol();
  endtask

  // S0 header: body is skipped while idle
  task automatic push_header();
    int unsigned i;
    int unsigned len;
    char_q.push_back(CH_S);
    char_q.push_back(CH_ZERO);
    len = $urandom_range(4, 40);
    for (i = 0; i < len; i++) char_q.push_back(hex_char(4'($urandom), 1'b0));
    live_chars += 2;
    push_eol();
  endtask

  // stray characters between records, never 'S' or 'g'
  task automatic push_noise(input int unsigned len);
    logic [7:0]  c;
    int unsigned i;
    for (i = 0; i < len; i++) begin
      c = 8'($urandom_range(0, 255));
      while (c == CH_S || c == CH_G) c = 8'($urandom_range(0, 255));
      char_q.push_back(c);
    end
  endtask

  // hold the sender until all owed results are in and the block is quiet
  task automatic wait_idle();
    int unsigned n;
    res_t        left;
    while (char_q.size() != 0 || in_valid) @(negedge clk);
    n = 0;
    while (due_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_PAD) @(negedge clk);
    while (due_results.size() != 0) begin
      left = due_results.pop_front();
      flag_mismatch("result never came, kind", 32'h0, 32'(left.kind));
    end
  endtask

  task automatic write_window(input logic [31:0] lo, input logic [31:0] hi);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WIN_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_WIN_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_lo = lo;
    win_hi = hi;
  endtask

  task automatic random_window();
    logic [31:0] lo;
    case ($urandom_range(0, 5))
      0: write_window(32'h0, 32'hFFFF_FFFF);
      1: begin
        lo = $urandom;
        write_window(lo, lo - 32'($urandom_range(1, 64)));
      end
      2: begin
        lo = $urandom;
        write_window(lo, lo);
      end
      default: begin
        lo = $urandom;
        write_window(lo, lo + 32'($urandom_range(0, 600)));
      end
    endcase
  endtask

  // addresses mostly around the current window edges
  function automatic logic [31:0] pick_addr();
    logic [31:0] span;
    span = (win_hi >= win_lo && win_hi - win_lo < 32'd1024) ? win_hi - win_lo : 32'd1024;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return 32'hFFFF_FFFF - 32'($urandom_range(0, 8));
      3, 4: return win_hi - 32'd8 + 32'($urandom_range(0, 16));
      default: return win_lo - 32'd8 + 32'($urandom_range(0, span + 16));
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned pick;
    int unsigned rec_n;
    logic [31:0] a;
    logic [7:0]  c;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle extremes, greetings, header, boundary records
    char_q.push_back(8'h00);
    char_q.push_back(8'hFF);
    char_q.push_back(8'h80);
    char_q.push_back(8'h7F);
    char_q.push_back(CH_ESC);
    char_q.push_back(CH_LF);
    push_header();
    push_record(CH_3, WIN_LOW_RESET, 0, 1'b0, 1'b0);
    push_record(CH_3, WIN_LOW_RESET - 32'd2, 4, 1'b0, 1'b0);
    push_record(CH_3, WIN_HIGH_RESET - 32'd1, 3, 1'b0, 1'b0);
    push_record(CH_3, 32'hFFFF_FFFE, 4, 1'b1, 1'b0);
    push_record(CH_3, WIN_LOW_RESET, 250, 1'b0, 1'b0);
    push_record(CH_7, $urandom, 0, 1'b0, 1'b0);
    push_record(CH_7, $urandom, 3, 1'b1, 1'b0);
    push_record(CH_3, WIN_LOW_RESET + 32'd16, 8, 1'b1, 1'b0);

    // window extremes
    write_window(32'h0, 32'hFFFF_FFFF);
    push_record(CH_3, $urandom, 6, 1'b0, 1'b0);
    write_window(32'hFFFF_FFFF, 32'h0);
    push_record(CH_3, 32'hFFFF_FFFE, 4, 1'b0, 1'b0);
    a = $urandom;
    write_window(a, a);
    push_record(CH_3, a - 32'd1, 3, 1'b0, 1'b0);
    write_window(32'h0, 32'h0);
    push_record(CH_3, 32'hFFFF_FFFF, 2, 1'b0, 1'b0);
    write_window(WIN_LOW_RESET, WIN_HIGH_RESET);

    // back-pressure: long receiver hold while a long record streams in
    push_record(CH_3, win_lo, 120, 1'b0, 1'b0);
    hold_token++;
    wait_idle();

    // random records
    rec_n = 0;
    while (live_chars < ITEM_GOAL) begin
      if (rec_n % 30 == 29) random_window();
      // queued items go out with idling before the final stretch starts
      if (idle_on && live_chars > ITEM_GOAL * 9 / 10) begin
        wait_idle();
        idle_on = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60)
        push_record(CH_3, pick_addr(), $urandom_range(0, 16), 1'($urandom_range(0, 1)), 1'b0);
      else if (pick < 62)
        push_record(CH_3, pick_addr(), $urandom_range(17, 250), 1'b0, 1'b0);
      else if (pick < 72)
        push_record(CH_7, $urandom, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0,
                    1'($urandom_range(0, 1)), 1'b0);
      else if (pick < 82)
        push_header();
      else if (pick < 95)
        push_noise($urandom_range(1, 6));
      else
        wait_idle();
      rec_n++;
    end
    idle_on = 1'b0;

    // one stopping event, then characters that must be ignored
    case ($urandom_range(0, 4))
      0: char_q.push_back(CH_G);
      1: begin
        c = 8'($urandom_range(0, 255));
        while (c == CH_ZERO || c == CH_3 || c == CH_7) c = 8'($urandom_range(0, 255));
        char_q.push_back(CH_S);
        char_q.push_back(c);
      end
      2: begin
        char_q.push_back(CH_S);
        char_q.push_back(($urandom_range(0, 1) == 0) ? CH_3 : CH_7);
        char_q.push_back(hex_char(4'd0, 1'b1));
        char_q.push_back(hex_char(4'($urandom_range(0, 4)), 1'b1));
      end
      3: push_record(CH_3, pick_addr(), $urandom_range(0, 6), 1'b1, 1'b1);
      default: push_record(CH_7, $urandom, 0, 1'b1, 1'b1);
    endcase
    char_q.push_back(CH_G);
    char_q.push_back(CH_S);
    char_q.push_back(CH_LF);
    repeat (40) char_q.push_back(8'($urandom_range(0, 255)));
    wait_idle();

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
